// ===== src/rc4_pkg.sv =====
// Shared types, program addresses and the control store for the RC4 sequencer.
`default_nettype none
package rc4_pkg;

    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] byte_value;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
    } out_item_t;

    typedef logic [3:0] upc_t;

    // program addresses
    localparam upc_t UA_IDLE = 4'd0;
    localparam upc_t UA_D0   = 4'd1;
    localparam upc_t UA_D1   = 4'd2;
    localparam upc_t UA_D2   = 4'd3;
    localparam upc_t UA_D3   = 4'd4;
    localparam upc_t UA_FILL = 4'd5;
    localparam upc_t UA_K0   = 4'd6;
    localparam upc_t UA_K1   = 4'd7;
    localparam upc_t UA_K2   = 4'd8;
    localparam upc_t UA_K3   = 4'd9;
    localparam upc_t UA_DONE = 4'd10;

    // S-box read address source
    typedef enum logic [2:0] {
        RD_NONE,
        RD_I1,      // i + 1
        RD_J1,      // j + S[i]
        RD_T,       // S[i] + S[j]
        RD_N,       // schedule step
        RD_JJ       // schedule j + S[n] + key
    } rd_sel_t;

    // S-box write address/data source
    typedef enum logic [2:0] {
        WR_NONE,
        WR_FILL,    // S[n] = n
        WR_I_SJ,    // S[i] = S[j]
        WR_J_SI,    // S[j] = old S[i]
        WR_JJ_SN,   // S[jj] = old S[n]
        WR_N_SJJ    // S[n] = old S[jj]
    } wr_sel_t;

    typedef enum logic [1:0] {
        NX_SEQ,
        NX_JUMP,
        NX_LOOP_N,  // back to target until n wraps, then fall through
        NX_DISPATCH
    } nxt_t;

    typedef struct packed {
        rd_sel_t rd;
        wr_sel_t wr;
        logic    lat_a;
        logic    lat_b;
        logic    upd_i;
        logic    upd_j;
        logic    upd_jj;
        logic    inc_n;
        logic    inc_kpos;
        logic    set_keyed;
        logic    clr_ij;
        logic    emit;
        nxt_t    nxt;
        upc_t    target;
    } ucw_t;

    function automatic ucw_t ucode(input upc_t addr);
        ucw_t w;
        w = '0;
        case (addr)
            UA_IDLE: w.nxt = NX_DISPATCH;
            UA_D0:
            begin
                w.rd    = RD_I1;
                w.upd_i = 1'b1;
            end
            UA_D1:
            begin
                w.rd    = RD_J1;
                w.lat_a = 1'b1;
                w.upd_j = 1'b1;
            end
            UA_D2:
            begin
                w.rd    = RD_T;
                w.wr    = WR_I_SJ;
                w.lat_b = 1'b1;
            end
            UA_D3:
            begin
                w.wr     = WR_J_SI;
                w.emit   = 1'b1;
                w.nxt    = NX_JUMP;
                w.target = UA_IDLE;
            end
            UA_FILL:
            begin
                w.wr        = WR_FILL;
                w.inc_n     = 1'b1;
                w.set_keyed = 1'b1;
                w.nxt       = NX_LOOP_N;
                w.target    = UA_FILL;
            end
            UA_K0: w.rd = RD_N;
            UA_K1:
            begin
                w.rd     = RD_JJ;
                w.lat_a  = 1'b1;
                w.upd_jj = 1'b1;
            end
            UA_K2:
            begin
                w.wr    = WR_JJ_SN;
                w.lat_b = 1'b1;
            end
            UA_K3:
            begin
                w.wr       = WR_N_SJJ;
                w.inc_n    = 1'b1;
                w.inc_kpos = 1'b1;
                w.nxt      = NX_LOOP_N;
                w.target   = UA_K0;
            end
            UA_DONE:
            begin
                w.clr_ij = 1'b1;
                w.nxt    = NX_JUMP;
                w.target = UA_IDLE;
            end
            default:
            begin
                w.nxt    = NX_JUMP;
                w.target = UA_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== src/rc4_stream_cipher.sv =====
// RC4 stream cipher: microcoded sequencer over a synchronous S-box and key store.
// Key item: written to the key store as it is accepted, while there is room; the item flagged last
//   then runs the key schedule (256-entry identity fill, swap steps K0 to K3 per entry, clear i and j).
// Data item: steps D0 to D3 and back to idle before the next accept; the result is
//   registered out of D3. All of it is bound by the single S-box port pair.
// Reset: indices, key count and sequencer clear; the S-box reads as all zero until keyed.
`default_nettype none
module rc4_stream_cipher
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 256
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_stall,
    input  wire in_item_t  item,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_item_t      result
);

    // key store indexing and count widths
    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KCNT_W = $clog2(MAX_KEY_BYTES + 1);

    // sequencer
    upc_t upc_reg, upc_next;
    ucw_t cw;

    // index state
    logic [7:0] i_reg, i_next;
    logic [7:0] j_reg, j_next;
    logic [7:0] n_reg, n_next;
    logic [7:0] jj_reg, jj_next;
    logic [KIDX_W-1:0] kpos_reg, kpos_next;
    logic [KCNT_W-1:0] key_count_reg, key_count_next;
    logic loading_reg, loading_next;
    logic keyed_reg, keyed_next;

    // datapath scratch registers (S[i]/S[n] in a, S[j]/S[jj] in b)
    logic [7:0] a_reg, a_next;
    logic [7:0] b_reg, b_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;

    // output stage
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    // memories
    logic       sbox_we, sbox_re;
    logic [7:0] sbox_waddr, sbox_wdata, sbox_raddr, sbox_rdata;
    logic                key_we;
    logic [KIDX_W-1:0]   key_waddr;
    logic [7:0]          key_rdata;

    logic       accept;
    logic       step_en;
    logic [7:0] s_rd;
    logic [7:0] j_sum, jj_sum, t_sum, ks;
    logic [KCNT_W-1:0] kc_eff, kpos_p1;
    logic       room;

    assign cw         = ucode(upc_reg);
    assign item_stall = (upc_reg != UA_IDLE);
    assign accept     = item_valid && !item_stall;

    // a finished item waits in D3 while the output register is full and stalled
    assign step_en = !(cw.emit && out_valid_reg && result_stall);

    // an unkeyed S-box is all zero
    assign s_rd   = keyed_reg ? sbox_rdata : 8'd0;
    assign j_sum  = j_reg + s_rd;
    assign jj_sum = jj_reg + s_rd + key_rdata;
    assign t_sum  = a_reg + b_reg;

    // keystream lookup was read in D2 before both swap writes landed; forward them
    always_comb
    begin
        if (t_sum == j_reg)
        begin
            ks = a_reg;
        end
        else if (t_sum == i_reg)
        begin
            ks = b_reg;
        end
        else
        begin
            ks = s_rd;
        end
    end

    // S-box read port
    always_comb
    begin
        sbox_re = step_en && (cw.rd != RD_NONE);
        case (cw.rd)
            RD_I1:   sbox_raddr = i_reg + 8'd1;
            RD_J1:   sbox_raddr = j_sum;
            RD_T:    sbox_raddr = a_reg + s_rd;
            RD_N:    sbox_raddr = n_reg;
            RD_JJ:   sbox_raddr = jj_sum;
            default: sbox_raddr = 8'd0;
        endcase
    end

    // S-box write port
    always_comb
    begin
        sbox_we = step_en && (cw.wr != WR_NONE);
        case (cw.wr)
            WR_FILL:
            begin
                sbox_waddr = n_reg;
                sbox_wdata = n_reg;
            end
            WR_I_SJ:
            begin
                sbox_waddr = i_reg;
                sbox_wdata = s_rd;
            end
            WR_J_SI:
            begin
                sbox_waddr = j_reg;
                sbox_wdata = a_reg;
            end
            WR_JJ_SN:
            begin
                sbox_waddr = jj_reg;
                sbox_wdata = a_reg;
            end
            WR_N_SJJ:
            begin
                sbox_waddr = n_reg;
                sbox_wdata = b_reg;
            end
            default:
            begin
                sbox_waddr = 8'd0;
                sbox_wdata = 8'd0;
            end
        endcase
    end

    // key collection: a key item after a closed key starts over at zero
    assign kc_eff    = loading_reg ? key_count_reg : '0;
    assign room      = (kc_eff < KCNT_W'(MAX_KEY_BYTES));
    assign key_we    = accept && (item.mode == MODE_KEY) && room;
    assign key_waddr = kc_eff[KIDX_W-1:0];
    assign kpos_p1   = KCNT_W'(kpos_reg) + KCNT_W'(1);

    always_comb
    begin
        upc_next       = upc_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        jj_next        = jj_reg;
        kpos_next      = kpos_reg;
        key_count_next = key_count_reg;
        loading_next   = loading_reg;
        keyed_next     = keyed_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (result_valid && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (step_en)
        begin
            if (cw.lat_a)
            begin
                a_next = s_rd;
            end
            if (cw.lat_b)
            begin
                b_next = s_rd;
            end
            if (cw.upd_i)
            begin
                i_next = i_reg + 8'd1;
            end
            if (cw.upd_j)
            begin
                j_next = j_sum;
            end
            if (cw.upd_jj)
            begin
                jj_next = jj_sum;
            end
            if (cw.inc_n)
            begin
                n_next = n_reg + 8'd1;
            end
            if (cw.inc_kpos)
            begin
                // key byte position wraps at the key length
                kpos_next = (kpos_p1 >= key_count_reg) ? '0 : kpos_p1[KIDX_W-1:0];
            end
            if (cw.set_keyed)
            begin
                keyed_next = 1'b1;
            end
            if (cw.clr_ij)
            begin
                i_next = 8'd0;
                j_next = 8'd0;
            end
            if (cw.emit)
            begin
                out_valid_next   = 1'b1;
                out_next.out_byte = byte_reg ^ ks;
                out_next.last_out = last_reg;
            end

            case (cw.nxt)
                NX_SEQ:    upc_next = upc_reg + upc_t'(1);
                NX_JUMP:   upc_next = cw.target;
                NX_LOOP_N: upc_next = (n_reg == 8'hFF) ? upc_reg + upc_t'(1) : cw.target;
                NX_DISPATCH:
                begin
                    if (accept)
                    begin
                        if (item.mode == MODE_DATA)
                        begin
                            byte_next = item.byte_value;
                            last_next = item.last;
                            upc_next  = UA_D0;
                        end
                        else
                        begin
                            key_count_next = room ? kc_eff + KCNT_W'(1) : kc_eff;
                            loading_next   = !item.last;
                            if (item.last)
                            begin
                                n_next    = 8'd0;
                                jj_next   = 8'd0;
                                kpos_next = '0;
                                upc_next  = UA_FILL;
                            end
                        end
                    end
                end
                default:   upc_next = UA_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= UA_IDLE;
            i_reg         <= 8'd0;
            j_reg         <= 8'd0;
            n_reg         <= 8'd0;
            jj_reg        <= 8'd0;
            kpos_reg      <= '0;
            key_count_reg <= '0;
            loading_reg   <= 1'b0;
            keyed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            jj_reg        <= jj_next;
            kpos_reg      <= kpos_next;
            key_count_reg <= key_count_next;
            loading_reg   <= loading_next;
            keyed_reg     <= keyed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (256)
    ) u_sbox (
        .clk   (clk),
        .we    (sbox_we),
        .waddr (sbox_waddr),
        .wdata (sbox_wdata),
        .re    (sbox_re),
        .raddr (sbox_raddr),
        .rdata (sbox_rdata)
    );

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (MAX_KEY_BYTES)
    ) u_key (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (item.byte_value),
        .re    (1'b1),
        .raddr (kpos_reg),
        .rdata (key_rdata)
    );

    // a new result only ever comes out of the last data step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(upc_reg == UA_D3))
        else $error("result without a finished data step");

    // an accepted data item starts the keystream program
    a_data_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.mode == MODE_DATA) |=> (upc_reg == UA_D0))
        else $error("data item not dispatched");

    // key position stays within the stored key during the swap loop
    a_kpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == UA_K0) |-> (KCNT_W'(kpos_reg) < key_count_reg))
        else $error("key position beyond key length");

endmodule
`default_nettype wire

// ===== src/rc4_ram.sv =====
// Generic single-write, single-read RAM with registered read (read-first).
`default_nettype none
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire
